// ===== sv/oale_pkg.sv =====
// Shared types and constants of the ordered array list engine.
`default_nettype none

package oale_pkg;

  // Number of list slots, one cell each.
  localparam int CAPACITY = 64;

  // Fixed field widths of the request and result items.
  localparam int KIND_W  = 3;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  // Internal widths derived from the capacity.
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int TREE_LVL = $clog2(CAPACITY);
  localparam int TREE_N  = 1 << TREE_LVL;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    K_INSERT     = 3'd0,
    K_REPLACE    = 3'd1,
    K_REMOVE_POS = 3'd2,
    K_REMOVE_VAL = 3'd3,
    K_READ       = 3'd4,
    K_FIND       = 3'd5
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Update operations broadcast to every cell.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  // Match request broadcast to the cells when an item is accepted.
  typedef struct packed {
    logic                     pos_mode;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
  } srch_t;

  // Update command broadcast to the cells in the apply cycle.
  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         tgt;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  // One node of the first-hit selection tree.
  typedef struct packed {
    logic                     hit;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] data;
  } node_t;

endpackage

`default_nettype wire

// ===== sv/ordered_array_list_engine.sv =====
// Top level of the ordered array list engine: cell row, hit tree and control.
// Sequence: the accepting edge loads the tree leaves, the search state waits while the
// registered hit tree settles level by level, and the apply state registers the result.
// One item at a time: busy drops in the strobe cycle, and the next item can be taken from then on.
// Results are presented for one cycle on out_valid; the receiver cannot stall.
// Reset clears the fill count, the sequencer and the result strobe; entries need no clearing pass.
`default_nettype none

module ordered_array_list_engine import oale_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [POS_W-1:0]         out_found_position,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int WAIT_W = $clog2(TREE_LVL + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_APPLY} state_t;

  state_t                   state_r;
  logic [WAIT_W-1:0]        wait_r;
  logic [CNT_W-1:0]         count_r;
  logic [KIND_W-1:0]        kind_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] value_r;

  logic                     out_valid_r;
  status_t                  status_r;
  logic signed [DATA_W-1:0] read_value_r;
  logic [POS_W-1:0]         found_pos_r;

  logic                     accept;
  srch_t                    srch;
  cell_ctl_t                ctl;
  node_t                    root;

  logic                     cell_hit   [TREE_N];
  logic signed [DATA_W-1:0] cell_entry [TREE_N];

  // Decisions of the apply cycle.
  status_t                  status_nxt;
  logic signed [DATA_W-1:0] read_value_nxt;
  logic [POS_W-1:0]         found_pos_nxt;
  logic [CNT_W-1:0]         count_nxt;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Match request seen by the cells while an item is being accepted.
  always_comb begin
    srch.pos_mode = !((in_kind == K_REMOVE_VAL) || (in_kind == K_FIND));
    srch.pos      = in_position;
    srch.value    = in_value;
    srch.count    = count_r;
  end

  // Row of cells; slots beyond the capacity pad the tree with misses.
  for (genvar i = 0; i < TREE_N; i++) begin : g_cell
    if (i < CAPACITY) begin : g_live
      logic signed [DATA_W-1:0] left_in;
      logic signed [DATA_W-1:0] right_in;
      if (i == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_mid_l
        assign left_in = cell_entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_in = cell_entry[i];
      end else begin : g_mid_r
        assign right_in = cell_entry[i+1];
      end
      oale_cell u_cell (
        .clk         (clk),
        .cell_idx    (IDX_W'(i)),
        .srch        (srch),
        .ctl         (ctl),
        .left_entry  (left_in),
        .right_entry (right_in),
        .entry       (cell_entry[i]),
        .leaf_hit    (cell_hit[i])
      );
    end else begin : g_pad
      assign cell_entry[i] = '0;
      assign cell_hit[i]   = 1'b0;
    end
  end

  oale_tree u_tree (
    .clk       (clk),
    .capture   (accept),
    .leaf_hit  (cell_hit),
    .leaf_data (cell_entry),
    .root      (root)
  );

  // Result and cell update for the held request, using the settled tree root.
  always_comb begin
    status_nxt     = ST_OK;
    read_value_nxt = '0;
    found_pos_nxt  = '0;
    count_nxt      = count_r;
    ctl.op         = CELL_HOLD;
    ctl.tgt        = IDX_W'(pos_r);
    ctl.value      = value_r;
    case (kind_t'(kind_r))
      K_INSERT: begin
        if (CMP_W'(pos_r) > CMP_W'(count_r)) begin
          status_nxt = ST_BAD_POS;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.op    = CELL_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      K_REPLACE: begin
        if (CMP_W'(pos_r) >= CMP_W'(count_r)) status_nxt = ST_BAD_POS;
        else ctl.op = CELL_WRITE;
      end
      K_REMOVE_POS: begin
        if (CMP_W'(pos_r) >= CMP_W'(count_r)) begin
          status_nxt = ST_BAD_POS;
        end else begin
          read_value_nxt = root.data;
          ctl.op         = CELL_REMOVE;
          count_nxt      = count_r - 1'b1;
        end
      end
      K_REMOVE_VAL: begin
        if (!root.hit) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          found_pos_nxt  = POS_W'(root.idx);
          read_value_nxt = root.data;
          ctl.op         = CELL_REMOVE;
          ctl.tgt        = root.idx;
          count_nxt      = count_r - 1'b1;
        end
      end
      K_READ: begin
        if (CMP_W'(pos_r) >= CMP_W'(count_r)) status_nxt = ST_BAD_POS;
        else read_value_nxt = root.data;
      end
      K_FIND: begin
        if (!root.hit) status_nxt = ST_NOT_FOUND;
        else found_pos_nxt = POS_W'(root.idx);
      end
      default: begin
        status_nxt = ST_BAD_POS;
      end
    endcase
    if (state_r != S_APPLY) ctl.op = CELL_HOLD;
  end

  // Sequencer: accept, wait for the tree to settle, apply and report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_SEARCH;
            wait_r  <= WAIT_W'(TREE_LVL - 1);
            kind_r  <= in_kind;
            pos_r   <= in_position;
            value_r <= in_value;
          end
        end
        S_SEARCH: begin
          if (wait_r == '0) state_r <= S_APPLY;
          else wait_r <= wait_r - 1'b1;
        end
        S_APPLY: begin
          state_r      <= S_IDLE;
          count_r      <= count_nxt;
          out_valid_r  <= 1'b1;
          status_r     <= status_nxt;
          read_value_r <= read_value_nxt;
          found_pos_r  <= found_pos_nxt;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_read_value     = read_value_r;
  assign out_found_position = found_pos_r;
  assign out_count          = COUNT_W'(count_r);

  // The fill count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A result strobe comes only once the engine has returned to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted item keeps the engine busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("engine not busy after accept");

  // A full status is reported only with a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  // The count moves only in the apply cycle.
  a_count_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_APPLY) |=> $stable(count_r))
    else $error("fill count changed outside apply");

endmodule

`default_nettype wire

// ===== sv/oale_cell.sv =====
// One list cell: holds an entry, flags a hit and shifts with its neighbors.
`default_nettype none

module oale_cell import oale_pkg::*; (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         cell_idx,
  input  srch_t                    srch,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic signed [DATA_W-1:0] right_entry,
  output logic signed [DATA_W-1:0] entry,
  output logic                     leaf_hit
);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  assign entry = entry_r;

  // A position request hits the addressed cell; a value request hits any
  // filled cell that holds the value.
  always_comb begin
    if (srch.pos_mode) begin
      leaf_hit = (CMP_W'(cell_idx) == CMP_W'(srch.pos));
    end else begin
      leaf_hit = (entry_r == srch.value) && (CMP_W'(cell_idx) < CMP_W'(srch.count));
    end
  end

  // Insert pulls from the left neighbor, remove pulls from the right one.
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      CELL_WRITE: begin
        if (cell_idx == ctl.tgt) entry_nxt = ctl.value;
      end
      CELL_INSERT: begin
        if (cell_idx == ctl.tgt) entry_nxt = ctl.value;
        else if (cell_idx > ctl.tgt) entry_nxt = left_entry;
      end
      CELL_REMOVE: begin
        if (cell_idx >= ctl.tgt) entry_nxt = right_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // Entry storage has no reset; unfilled slots are never reported.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/oale_tree.sv =====
// Registered tree that picks the lowest-numbered hit among the cells.
`default_nettype none

module oale_tree import oale_pkg::*; (
  input  logic                     clk,
  input  logic                     capture,
  input  logic                     leaf_hit  [TREE_N],
  input  logic signed [DATA_W-1:0] leaf_data [TREE_N],
  output node_t                    root
);

  // Heap order: node n has children 2n and 2n+1, leaves sit at TREE_N and up.
  node_t node_r [1:2*TREE_N-1];

  // The lower child wins whenever it holds a hit.
  function automatic node_t pick(input node_t lo, input node_t hi);
    node_t res;
    res = lo.hit ? lo : hi;
    res.hit = lo.hit | hi.hit;
    return res;
  endfunction

  // Leaves load on accept; each inner level is registered and settles in the cycle after its children.
  always_ff @(posedge clk) begin
    for (int n = 1; n < TREE_N; n++) begin
      node_r[n] <= pick(node_r[2*n], node_r[2*n+1]);
    end
    if (capture) begin
      for (int j = 0; j < TREE_N; j++) begin
        node_r[TREE_N+j].hit  <= leaf_hit[j];
        node_r[TREE_N+j].idx  <= IDX_W'(j);
        node_r[TREE_N+j].data <= leaf_data[j];
      end
    end
  end

  assign root = node_r[1];

endmodule

`default_nettype wire

// ===== sim/ordered_array_list_engine_test.sv =====
// Self-checking testbench for the ordered array list engine: directed table, then random items.
module ordered_array_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import oale_pkg::*;

  // Kinds that the block must reject, and word extremes.
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] WORD_ONES = -32'sd1;

  // Item latency of the block; used for the quiet time at the end.
  localparam int LATENCY = $clog2(CAPACITY) + 1;
  localparam int PRINT_LIMIT = 100;

  // Random phases: balanced, filling, draining, then unstructured items.
  localparam int PHASE_NOISE = 3;
  localparam int PHASE_ITEMS [4] = '{600, 550, 450, 226};
  localparam int INSERT_PCT [4] = '{30, 70, 10, 0};
  localparam int REMOVE_PCT [4] = '{25, 10, 65, 0};

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [COUNT_W-1:0]       count;
  } list_result_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     typed;
    list_result_t             result;
  } directed_row_t;

  // Directed items. Rows with typed set carry their result; the rest use the list model.
  localparam directed_row_t DIRECTED [24] = '{
    '{K_READ,       6'd0,  32'sd0,     1'b1, '{ST_BAD_POS,   32'sd0,   6'd0, 7'd0}},
    '{K_REMOVE_POS, 6'd0,  32'sd0,     1'b1, '{ST_BAD_POS,   32'sd0,   6'd0, 7'd0}},
    '{K_REPLACE,    6'd0,  32'sd1234,  1'b1, '{ST_BAD_POS,   32'sd0,   6'd0, 7'd0}},
    '{K_REMOVE_VAL, 6'd0,  32'sd5,     1'b1, '{ST_NOT_FOUND, 32'sd0,   6'd0, 7'd0}},
    '{K_FIND,       6'd0,  32'sd0,     1'b1, '{ST_NOT_FOUND, 32'sd0,   6'd0, 7'd0}},
    '{K_INSERT,     6'd1,  32'sd7,     1'b1, '{ST_BAD_POS,   32'sd0,   6'd0, 7'd0}},
    '{KIND_SPARE_6, 6'd0,  32'sd0,     1'b1, '{ST_BAD_POS,   32'sd0,   6'd0, 7'd0}},
    '{KIND_SPARE_7, 6'd63, WORD_ONES,  1'b1, '{ST_BAD_POS,   32'sd0,   6'd0, 7'd0}},
    '{K_INSERT,     6'd0,  WORD_MIN,   1'b1, '{ST_OK,        32'sd0,   6'd0, 7'd1}},
    '{K_INSERT,     6'd1,  WORD_MAX,   1'b1, '{ST_OK,        32'sd0,   6'd0, 7'd2}},
    '{K_INSERT,     6'd0,  32'sd0,     1'b1, '{ST_OK,        32'sd0,   6'd0, 7'd3}},
    '{K_INSERT,     6'd63, WORD_ONES,  1'b1, '{ST_BAD_POS,   32'sd0,   6'd0, 7'd3}},
    '{K_READ,       6'd1,  32'sd0,     1'b1, '{ST_OK,        WORD_MIN, 6'd0, 7'd3}},
    '{K_READ,       6'd2,  32'sd0,     1'b1, '{ST_OK,        WORD_MAX, 6'd0, 7'd3}},
    '{K_FIND,       6'd0,  WORD_MAX,   1'b1, '{ST_OK,        32'sd0,   6'd2, 7'd3}},
    '{K_READ,       6'd3,  32'sd0,     1'b1, '{ST_BAD_POS,   32'sd0,   6'd0, 7'd3}},
    '{K_REPLACE,    6'd2,  WORD_ONES,  1'b0, '0},
    '{K_INSERT,     6'd3,  32'sd0,     1'b0, '0},
    '{K_FIND,       6'd0,  32'sd0,     1'b0, '0},
    '{K_REMOVE_VAL, 6'd0,  32'sd0,     1'b0, '0},
    '{K_REMOVE_POS, 6'd1,  32'sd0,     1'b0, '0},
    '{K_REMOVE_POS, 6'd63, 32'sd0,     1'b0, '0},
    '{K_REMOVE_VAL, 6'd0,  32'sh5555_aaaa, 1'b0, '0},
    '{K_INSERT,     6'd2,  32'sh2aaa_5555, 1'b0, '0}
  };

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KIND_W-1:0]        in_kind = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_read_value;
  logic [POS_W-1:0]         out_found_position;
  logic [COUNT_W-1:0]       out_count;

  // Shadow copy of the list contents and fill count.
  logic signed [DATA_W-1:0] shadow_words [CAPACITY];
  int                       shadow_fill = 0;
  int                       peak_fill = 0;

  list_result_t pending_results [$];
  int           mismatch_count = 0;
  int           results_checked = 0;
  int           items_sent = 0;
  int           kind_tally [8] = '{default: 0};
  int           status_tally [4] = '{default: 0};
  bit           steady_stream = 1'b0;

  ordered_array_list_engine dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_count          (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Close the gap left by the word taken out at idx.
  function automatic void drop_word(input int idx);
    for (int i = idx; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i + 1];
    shadow_fill--;
  endfunction

  // Apply one item to the shadow list and return the result it must produce.
  function automatic list_result_t list_predict(input logic [KIND_W-1:0] k,
                                                input logic [POS_W-1:0] p,
                                                input logic signed [DATA_W-1:0] v);
    list_result_t r;
    int hit;
    r = '{ST_OK, '0, '0, '0};
    hit = -1;
    // First match among the filled entries only.
    for (int i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_words[i] == v) hit = i;
    end
    case (k)
      K_INSERT: begin
        if (p > shadow_fill) r.status = ST_BAD_POS;
        else if (shadow_fill >= CAPACITY) r.status = ST_FULL;
        else begin
          for (int i = shadow_fill; i > p; i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[p] = v;
          shadow_fill++;
        end
      end
      K_REPLACE: begin
        if (p >= shadow_fill) r.status = ST_BAD_POS;
        else shadow_words[p] = v;
      end
      K_REMOVE_POS: begin
        if (p >= shadow_fill) r.status = ST_BAD_POS;
        else begin
          r.read_value = shadow_words[p];
          drop_word(p);
        end
      end
      K_REMOVE_VAL: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          r.found_position = POS_W'(hit);
          r.read_value = shadow_words[hit];
          drop_word(hit);
        end
      end
      K_READ: begin
        if (p >= shadow_fill) r.status = ST_BAD_POS;
        else r.read_value = shadow_words[p];
      end
      K_FIND: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.found_position = POS_W'(hit);
      end
      default: r.status = ST_BAD_POS;
    endcase
    r.count = COUNT_W'(shadow_fill);
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $realtime, what);
  endtask

  // Present one item, after a random pause unless streaming, wait until it is taken, and record its result.
  task automatic drive_item(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                            input logic signed [DATA_W-1:0] v, input logic typed,
                            input list_result_t typed_result);
    int unsigned gap;
    bit from_idle;
    list_result_t predicted;
    gap = steady_stream ? 0 : $urandom_range(0, 5);
    from_idle = !steady_stream && ($urandom_range(0, 1) == 1);
    // The pause counts either from the last acceptance or from the block going idle.
    if (gap != 0 || from_idle) begin
      start <= 1'b0;
      if (from_idle) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= k;
    in_position <= p;
    in_value <= v;
    do @(posedge clk); while (busy);
    predicted = list_predict(k, p, v);
    pending_results.push_back(typed ? typed_result : predicted);
    items_sent++;
    kind_tally[k]++;
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Draw one random item; positions and values lean toward the filled part of the list.
  task automatic pick_item(input int phase, output logic [KIND_W-1:0] k,
                           output logic [POS_W-1:0] p, output logic signed [DATA_W-1:0] v);
    int unsigned roll;
    int top;
    roll = $urandom_range(0, 99);
    if (phase == PHASE_NOISE) k = KIND_W'($urandom_range(0, 7));
    else if (roll < INSERT_PCT[phase]) k = K_INSERT;
    else if (roll < INSERT_PCT[phase] + REMOVE_PCT[phase]) begin
      k = ($urandom_range(0, 1) == 1) ? K_REMOVE_POS : K_REMOVE_VAL;
    end else begin
      case ($urandom_range(0, 2))
        0: k = K_REPLACE;
        1: k = K_READ;
        default: k = K_FIND;
      endcase
    end
    top = (k == K_INSERT) ? shadow_fill : shadow_fill - 1;
    if (phase == PHASE_NOISE || top < 0 || $urandom_range(0, 3) == 0) begin
      p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    end else begin
      p = POS_W'($urandom_range(0, (top > (1 << POS_W) - 1) ? (1 << POS_W) - 1 : top));
    end
    // Words already in the list and a small pool make hits and duplicates common.
    case ($urandom_range(0, 3))
      0: v = (shadow_fill > 0) ? shadow_words[$urandom_range(0, shadow_fill - 1)] : $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: v = WORD_MIN;
          1: v = WORD_MAX;
          2: v = WORD_ONES;
          default: v = $urandom_range(0, 3);
        endcase
      end
      default: v = $urandom;
    endcase
  endtask

  // Compare every result strobe with the oldest outstanding expectation.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result strobe with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_tally[want.status]++;
        if (out_status !== want.status) begin
          flag_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                                  results_checked, out_status, want.status));
        end
        if (out_read_value !== want.read_value) begin
          flag_mismatch($sformatf("result %0d read_value: got %0d, expected %0d",
                                  results_checked, out_read_value, want.read_value));
        end
        if (out_found_position !== want.found_position) begin
          flag_mismatch($sformatf("result %0d found_position: got %0d, expected %0d",
                                  results_checked, out_found_position, want.found_position));
        end
        if (out_count !== want.count) begin
          flag_mismatch($sformatf("result %0d count: got %0d, expected %0d",
                                  results_checked, out_count, want.count));
        end
      end
    end
  end

  // Main sequence: reset, directed table, four random phases, then drain.
  initial begin
    logic [KIND_W-1:0]        k;
    logic [POS_W-1:0]         p;
    logic signed [DATA_W-1:0] v;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) begin
      drive_item(DIRECTED[i].kind, DIRECTED[i].position, DIRECTED[i].value,
                 DIRECTED[i].typed, DIRECTED[i].result);
    end
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      for (int n = 0; n < PHASE_ITEMS[phase]; n++) begin
        // Switch between back-to-back stretches and stretches with random pauses.
        if (n % 64 == 0) steady_stream = ($urandom_range(0, 2) == 0);
        pick_item(phase, k, p, v);
        drive_item(k, p, v, 1'b0, '0);
      end
    end
    settle();
    repeat (2 * LATENCY) @(posedge clk);
    $display("Sent %0d items: insert %0d, replace %0d, remove at position %0d, %s %0d, %s %0d,",
             items_sent, kind_tally[K_INSERT], kind_tally[K_REPLACE], kind_tally[K_REMOVE_POS],
             "remove value", kind_tally[K_REMOVE_VAL], "read", kind_tally[K_READ]);
    $display("find %0d, unknown %0d; peak fill %0d of %0d; %0d results (%0d ok, %s %0d, %s %0d, %s %0d).",
             kind_tally[K_FIND], kind_tally[KIND_SPARE_6] + kind_tally[KIND_SPARE_7],
             peak_fill, CAPACITY, results_checked, status_tally[ST_OK],
             "bad position", status_tally[ST_BAD_POS], "full", status_tally[ST_FULL],
             "not found", status_tally[ST_NOT_FOUND]);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/oale_pkg.sv
sv/oale_cell.sv
sv/oale_tree.sv
sv/ordered_array_list_engine.sv
sim/ordered_array_list_engine_test.sv
